// ===== src/tlab_pkg.sv =====
package tlab_pkg;

	localparam int unsigned NUM_LAYERS = 3;
	localparam int unsigned CHAN_W     = 8;
	localparam int unsigned NUM_CHAN   = 3;
	localparam int unsigned COLOR_W    = CHAN_W * NUM_CHAN;
	localparam int unsigned SUM_W      = 2 * CHAN_W;
	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [CHAN_W-1:0] alpha_t;

	// overlays still to be applied sit from element 0 upwards
	typedef struct packed {
		color_t [NUM_LAYERS-1:0] ov_color;
		alpha_t [NUM_LAYERS-1:0] ov_alpha;
		color_t                  pix;
	} item_t;

	// floor(t / 255) for any 16-bit t whose quotient fits in 8 bits (t <= 65279)
	function automatic logic [CHAN_W-1:0] div255(input logic [SUM_W-1:0] t);
		logic [SUM_W:0] s;
		s = {1'b0, t} + {{SUM_W{1'b0}}, 1'b1} + {{(CHAN_W+1){1'b0}}, t[SUM_W-1:CHAN_W]};
		return s[SUM_W-1:CHAN_W];
	endfunction

endpackage

// ===== src/terrain_layer_alpha_blend.sv =====
// channel   dir  bits  contents (lowest bit up)
// s_axis    in   120   base_color, overlay1..3_color, overlay1..3_alpha
// m_axis    out  24    blended_color
//
// one pixel per clock while the output is not stalled, output taken straight from the last stage register
// each overlay is a two-stage unit: multiply-add, then divide by 255
// reset clears the valid bits only, data registers are not reset
// per-stage ready lets a bubble close up while the output is stalled
module terrain_layer_alpha_blend (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [119:0] s_axis_tdata,  // base_color, overlay1_color, overlay2_color,
	                                    // overlay3_color, overlay1_alpha, overlay2_alpha,
	                                    // overlay3_alpha
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [23:0]  m_axis_tdata   // blended_color
);

	tlab_pkg::item_t [tlab_pkg::NUM_LAYERS:0] item;
	logic [tlab_pkg::NUM_LAYERS:0]            valid;
	logic [tlab_pkg::NUM_LAYERS:0]            ready;

	assign item[0].pix         = s_axis_tdata[23:0];
	assign item[0].ov_color[0] = s_axis_tdata[47:24];
	assign item[0].ov_color[1] = s_axis_tdata[71:48];
	assign item[0].ov_color[2] = s_axis_tdata[95:72];
	assign item[0].ov_alpha[0] = s_axis_tdata[103:96];
	assign item[0].ov_alpha[1] = s_axis_tdata[111:104];
	assign item[0].ov_alpha[2] = s_axis_tdata[119:112];

	assign valid[0]      = s_axis_tvalid;
	assign s_axis_tready = ready[0];

	for (genvar g = 0; g < tlab_pkg::NUM_LAYERS; g++) begin : g_layer
		tlab_layer u_layer (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid[g]),
			.in_ready  (ready[g]),
			.in_item   (item[g]),
			.out_valid (valid[g+1]),
			.out_ready (ready[g+1]),
			.out_item  (item[g+1])
		);
	end

	assign m_axis_tvalid                 = valid[tlab_pkg::NUM_LAYERS];
	assign ready[tlab_pkg::NUM_LAYERS]   = m_axis_tready;
	assign m_axis_tdata                  = item[tlab_pkg::NUM_LAYERS].pix;

endmodule

// ===== src/tlab_layer.sv =====
module tlab_layer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  tlab_pkg::item_t in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output tlab_pkg::item_t out_item
);

	logic                                               valid_s1;
	logic                                               valid_s2;
	logic                                               ready_s1;
	logic                                               ready_s2;
	logic [tlab_pkg::NUM_CHAN-1:0][tlab_pkg::SUM_W-1:0] sum_d;
	logic [tlab_pkg::NUM_CHAN-1:0][tlab_pkg::SUM_W-1:0] sum_s1;
	tlab_pkg::item_t                                    rest_d;
	tlab_pkg::item_t                                    rest_s1;
	tlab_pkg::item_t                                    item_d;
	tlab_pkg::item_t                                    item_s2;
	logic [tlab_pkg::CHAN_W-1:0]                        inv_a;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// weighted sum per channel
	always_comb begin
		inv_a = tlab_pkg::CHAN_MAX - in_item.ov_alpha[0];
		for (int c = 0; c < tlab_pkg::NUM_CHAN; c++) begin
			sum_d[c] = {{tlab_pkg::CHAN_W{1'b0}}, in_item.pix[c*tlab_pkg::CHAN_W +: tlab_pkg::CHAN_W]}
				* {{tlab_pkg::CHAN_W{1'b0}}, inv_a}
				+ {{tlab_pkg::CHAN_W{1'b0}},
					in_item.ov_color[0][c*tlab_pkg::CHAN_W +: tlab_pkg::CHAN_W]}
				* {{tlab_pkg::CHAN_W{1'b0}}, in_item.ov_alpha[0]};
		end
		rest_d          = in_item;
		rest_d.ov_color = {{tlab_pkg::COLOR_W{1'b0}},
			in_item.ov_color[tlab_pkg::NUM_LAYERS-1:1]};
		rest_d.ov_alpha = {{tlab_pkg::CHAN_W{1'b0}},
			in_item.ov_alpha[tlab_pkg::NUM_LAYERS-1:1]};
	end

	// scale back by 1/255
	always_comb begin
		item_d = rest_s1;
		for (int c = 0; c < tlab_pkg::NUM_CHAN; c++) begin
			item_d.pix[c*tlab_pkg::CHAN_W +: tlab_pkg::CHAN_W] = tlab_pkg::div255(sum_s1[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			sum_s1  <= sum_d;
			rest_s1 <= rest_d;
		end
		if (ready_s2 && valid_s1) begin
			item_s2 <= item_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

endmodule

// ===== src/tlab_checker.sv =====
module tlab_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [119:0] s_axis_tdata,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [23:0]  m_axis_tdata
);

	logic [5:0] rdy_hist_q;
	logic       s_acc;
	logic       all_clear;
	logic       top_opaque;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy_hist_q <= '0;
		end else begin
			rdy_hist_q <= {rdy_hist_q[4:0], m_axis_tready};
		end
	end

	assign s_acc      = s_axis_tvalid && s_axis_tready;
	assign all_clear  = s_axis_tdata[119:96] == 24'd0;
	assign top_opaque = s_axis_tdata[119:112] == tlab_pkg::CHAN_MAX;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output data changed while stalled");

	// transparent overlays pass the base through while the output has been ready throughout
	a_pass_base: assert property (@(posedge clk) disable iff (!arst_n)
		(&rdy_hist_q) && $past(s_acc && all_clear, 6)
		|-> m_axis_tvalid && m_axis_tdata == $past(s_axis_tdata[23:0], 6))
		else $error("base not passed through");

	// an opaque top overlay wins
	a_top_wins: assert property (@(posedge clk) disable iff (!arst_n)
		(&rdy_hist_q) && $past(s_acc && top_opaque, 6)
		|-> m_axis_tvalid && m_axis_tdata == $past(s_axis_tdata[95:72], 6))
		else $error("opaque top overlay not taken");

endmodule

bind terrain_layer_alpha_blend tlab_checker u_tlab_checker (.*);
